// File: design/lspid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lspid_pkg: shared types, constants and microcode for the line PID block
// Holds the field widths, the sensor error table, the control word layout
// and the microcode program that runs one control step.
// ----------------------------------------------------------------------------
package lspid_pkg;

    // Field widths
    localparam int SENSOR_W  = 5;
    localparam int TICKS_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Number of sensors that carry a weight
    localparam int SENSOR_COUNT = 5;

    // Internal widths
    localparam int ERR_W    = 12;                 // signed Q.8, -1024..1024
    localparam int DIFF_W   = ERR_W + 1;
    localparam int INTEG_W  = 40;
    localparam int INTEG_HW = INTEG_W / 2;        // integral split for the multiplier
    localparam int IPROD_W  = 29;                 // error * ticks
    localparam int DPROD_W  = 30;                 // (error - last) * ticks
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 18;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 57;
    localparam int FRAC_W   = 8;
    localparam int CORR_W   = ACC_W - FRAC_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH = 3'd4;

    // Integral saturation bounds
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // Mean weight of the active sensors, weights -4,-2,0,2,4, in Q.8,
    // truncated toward zero; zero when no sensor is active.
    localparam logic signed [ERR_W-1:0] ERR_LUT [2**SENSOR_W] = '{
        12'sd0,    -12'sd1024, -12'sd512,  -12'sd768,
        12'sd0,    -12'sd512,  -12'sd256,  -12'sd512,
        12'sd512,  -12'sd256,  12'sd0,     -12'sd341,
        12'sd256,  -12'sd170,  12'sd0,     -12'sd256,
        -12'sd1024 + 12'sd2047 + 12'sd1,   // 16: sensor 4 alone, +1024
        12'sd0,    12'sd256,   -12'sd170,
        12'sd512,  12'sd0,     12'sd170,   -12'sd128,
        12'sd768,  12'sd170,   12'sd341,   12'sd0,
        12'sd512,  12'sd128,   12'sd256,   12'sd0
    };

    // Only sensors below SENSOR_COUNT are looked at
    function automatic logic [SENSOR_W-1:0] sensor_mask();
        logic [SENSOR_W-1:0] m;
        for (int i = 0; i < SENSOR_W; i++) begin
            m[i] = (i < SENSOR_COUNT);
        end
        return m;
    endfunction

    // Datapath selects
    typedef enum logic [2:0] {
        A_ERR,
        A_DIFF,
        A_ILO,
        A_IHI,
        A_DPROD
    } a_sel_t;

    typedef enum logic [1:0] {
        B_TICKS,
        B_GP,
        B_GI,
        B_GD
    } b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_HI
    } acc_op_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_NO_INPUT,
        COND_OUT_BUSY
    } cond_t;

    // Program steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_IPROD  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DPROD  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_PTERM  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ILO    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_IHI    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DTERM  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_SUM    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CLIPLO = 4'd8;
    localparam logic [STEP_W-1:0] STEP_OUT    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_LAST   = STEP_OUT;

    // Control word
    typedef struct packed {
        a_sel_t            a_sel;
        b_sel_t            b_sel;
        acc_op_t           acc_op;
        logic              integ_upd;
        logic              deriv_ld;
        logic              clip_lo;
        logic              take_in;
        logic              out_ld;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } uop_t;

    // Qualified controls from sequencer to datapath
    typedef struct packed {
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t acc_op;
        logic    integ_upd;
        logic    deriv_ld;
        logic    clip_lo;
        logic    take_in;
        logic    out_ld;
    } ctl_t;

    localparam uop_t UOP_NOP = '{
        a_sel:     A_ERR,
        b_sel:     B_TICKS,
        acc_op:    ACC_HOLD,
        integ_upd: 1'b0,
        deriv_ld:  1'b0,
        clip_lo:   1'b0,
        take_in:   1'b0,
        out_ld:    1'b0,
        cond:      COND_NONE,
        target:    STEP_WAIT
    };

    // Microcode ROM. The multiplier output is registered, so each step
    // consumes the product started one step earlier.
    function automatic uop_t uop_rom(input logic [STEP_W-1:0] addr);
        uop_t u;
        u = UOP_NOP;
        case (addr)
            STEP_WAIT: begin
                u.take_in = 1'b1;
                u.cond    = COND_NO_INPUT;
                u.target  = STEP_WAIT;
            end
            STEP_IPROD: begin
                u.a_sel = A_ERR;
                u.b_sel = B_TICKS;
            end
            STEP_DPROD: begin
                u.a_sel     = A_DIFF;
                u.b_sel     = B_TICKS;
                u.integ_upd = 1'b1;
            end
            STEP_PTERM: begin
                u.a_sel    = A_ERR;
                u.b_sel    = B_GP;
                u.deriv_ld = 1'b1;
            end
            STEP_ILO: begin
                u.a_sel  = A_ILO;
                u.b_sel  = B_GI;
                u.acc_op = ACC_LOAD;
            end
            STEP_IHI: begin
                u.a_sel  = A_IHI;
                u.b_sel  = B_GI;
                u.acc_op = ACC_ADD;
            end
            STEP_DTERM: begin
                u.a_sel  = A_DPROD;
                u.b_sel  = B_GD;
                u.acc_op = ACC_ADD_HI;
            end
            STEP_SUM: begin
                u.acc_op = ACC_ADD;
            end
            STEP_CLIPLO: begin
                u.clip_lo = 1'b1;
            end
            STEP_OUT: begin
                u.out_ld = 1'b1;
                u.cond   = COND_OUT_BUSY;
                u.target = STEP_OUT;
            end
            default: begin
                u = UOP_NOP;
            end
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// File: design/lspid_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lspid_seq: microcode sequencer
// Step counter addressing the program ROM, with wait-in-place jumps on
// missing input and on a full output register.
// ----------------------------------------------------------------------------
module lspid_seq (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire logic          out_busy,
    output logic               in_ready,
    output lspid_pkg::ctl_t    ctl
);
    import lspid_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    uop_t              uop;
    logic              cond_hit;

    assign uop = uop_rom(step_reg);

    always_comb begin
        case (uop.cond)
            COND_NONE:     cond_hit = 1'b0;
            COND_NO_INPUT: cond_hit = !in_valid;
            COND_OUT_BUSY: cond_hit = out_busy;
            default:       cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        if (cond_hit) begin
            step_next = uop.target;
        end else if (step_reg == STEP_LAST) begin
            step_next = STEP_WAIT;
        end else begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

    // Input side is open for the whole of the wait step
    assign in_ready = uop.take_in;

    always_comb begin
        ctl.a_sel     = uop.a_sel;
        ctl.b_sel     = uop.b_sel;
        ctl.acc_op    = uop.acc_op;
        ctl.integ_upd = uop.integ_upd;
        ctl.deriv_ld  = uop.deriv_ld;
        ctl.clip_lo   = uop.clip_lo;
        ctl.take_in   = uop.take_in && in_valid;
        ctl.out_ld    = uop.out_ld && !out_busy;
    end

endmodule
`default_nettype wire

// File: design/lspid_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lspid_dp: PID datapath
// One shared 32x18 signed multiplier with registered product, the integral
// and previous-error state, a wide accumulator and the clip compares.
// ----------------------------------------------------------------------------
module lspid_dp (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire lspid_pkg::ctl_t                       ctl,
    input  wire logic [lspid_pkg::SENSOR_W-1:0]        sensor_bits,
    input  wire logic [lspid_pkg::TICKS_W-1:0]         elapsed_ticks,
    input  wire logic                                  clear_integral,
    input  wire logic signed [lspid_pkg::GAIN_W-1:0]   gain_p,
    input  wire logic signed [lspid_pkg::GAIN_W-1:0]   gain_i,
    input  wire logic signed [lspid_pkg::GAIN_W-1:0]   gain_d,
    input  wire logic signed [lspid_pkg::LIMIT_W-1:0]  limit_low,
    input  wire logic signed [lspid_pkg::LIMIT_W-1:0]  limit_high,
    output logic signed [lspid_pkg::LIMIT_W-1:0]       result,
    output logic                                       result_clip
);
    import lspid_pkg::*;

    // State
    logic signed [ERR_W-1:0]   last_err_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;

    // Working registers
    logic signed [ERR_W-1:0]   err_reg;
    logic [TICKS_W-1:0]        ticks_reg;
    logic signed [DPROD_W-1:0] dprod_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [CORR_W-1:0]  corr_reg;
    logic                      clip_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [CORR_W-1:0]  shifted;
    logic signed [CORR_W-1:0]  lim_lo_ext;
    logic signed [CORR_W-1:0]  lim_hi_ext;
    logic                      over_hi;

    assign diff = {err_reg[ERR_W-1], err_reg} - {last_err_reg[ERR_W-1], last_err_reg};

    always_comb begin
        case (ctl.a_sel)
            A_ERR:   mul_a = {{(MUL_A_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
            A_DIFF:  mul_a = {{(MUL_A_W-DIFF_W){diff[DIFF_W-1]}}, diff};
            A_ILO:   mul_a = {{(MUL_A_W-INTEG_HW){1'b0}}, integ_reg[INTEG_HW-1:0]};
            A_IHI:   mul_a = {{(MUL_A_W-INTEG_HW){integ_reg[INTEG_W-1]}},
                              integ_reg[INTEG_W-1:INTEG_HW]};
            A_DPROD: mul_a = {{(MUL_A_W-DPROD_W){dprod_reg[DPROD_W-1]}}, dprod_reg};
            default: mul_a = '0;
        endcase
    end

    always_comb begin
        case (ctl.b_sel)
            B_TICKS: mul_b = {{(MUL_B_W-TICKS_W){1'b0}}, ticks_reg};
            B_GP:    mul_b = {{(MUL_B_W-GAIN_W){gain_p[GAIN_W-1]}}, gain_p};
            B_GI:    mul_b = {{(MUL_B_W-GAIN_W){gain_i[GAIN_W-1]}}, gain_i};
            B_GD:    mul_b = {{(MUL_B_W-GAIN_W){gain_d[GAIN_W-1]}}, gain_d};
            default: mul_b = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Integral: add error * ticks, saturate to 40 bits
    assign integ_sum = {integ_reg[INTEG_W-1], integ_reg}
                     + {{(INTEG_W+1-IPROD_W){prod_reg[IPROD_W-1]}}, prod_reg[IPROD_W-1:0]};

    always_comb begin
        integ_next = integ_reg;
        if (ctl.take_in && clear_integral) begin
            integ_next = '0;
        end else if (ctl.integ_upd) begin
            if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
                integ_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
            end else begin
                integ_next = integ_sum[INTEG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg    <= '0;
            last_err_reg <= '0;
        end else begin
            integ_reg <= integ_next;
            if (ctl.deriv_ld) begin
                last_err_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.take_in) begin
            err_reg   <= ERR_LUT[sensor_bits & sensor_mask()];
            ticks_reg <= elapsed_ticks;
        end
        if (ctl.deriv_ld) begin
            dprod_reg <= prod_reg[DPROD_W-1:0];
        end
    end

    // Accumulator; the upper integral half lands 20 bits up
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb begin
        case (ctl.acc_op)
            ACC_HOLD:   acc_next = acc_reg;
            ACC_LOAD:   acc_next = prod_ext;
            ACC_ADD:    acc_next = acc_reg + prod_ext;
            ACC_ADD_HI: acc_next = acc_reg + {prod_ext[ACC_W-INTEG_HW-1:0], {INTEG_HW{1'b0}}};
            default:    acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // Arithmetic shift gives floor division by 256
    assign shifted    = acc_reg[ACC_W-1:FRAC_W];
    assign lim_lo_ext = {{(CORR_W-LIMIT_W){limit_low[LIMIT_W-1]}}, limit_low};
    assign lim_hi_ext = {{(CORR_W-LIMIT_W){limit_high[LIMIT_W-1]}}, limit_high};

    always_ff @(posedge aclk) begin
        if (ctl.clip_lo) begin
            if (shifted < lim_lo_ext) begin
                corr_reg <= lim_lo_ext;
                clip_reg <= 1'b1;
            end else begin
                corr_reg <= shifted;
                clip_reg <= 1'b0;
            end
        end
    end

    // High bound applied last, so it wins when the bounds cross
    assign over_hi     = corr_reg > lim_hi_ext;
    assign result      = over_hi ? limit_high : corr_reg[LIMIT_W-1:0];
    assign result_clip = clip_reg || over_hi;

endmodule
`default_nettype wire

// File: design/line_sensor_pid_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_sensor_pid_controller: PID correction from line-sensor readings
// Input transfer: s_sensor_bits, s_elapsed_ticks, s_clear_integral on
// s_valid/s_ready. Each input transfer yields one result transfer of
// m_correction (signed Q24.8) and m_clipped on m_valid/m_ready.
// Gains and clip limits are written through cfg_valid/cfg_ready with
// cfg_index (0 gain_p, 1 gain_i, 2 gain_d, 3 limit_low, 4 limit_high) and
// cfg_data; cfg_ready is always high. Write them only while idle.
// A microcoded step sequence drives one shared 32x18 multiplier for the
// integral, derivative and four gain products, then two clip compares;
// a new item is taken only once the previous item has run the sequence.
// The result sits in an output register, so the next item is taken and
// processed while a result waits; the sequence holds in its final step if
// the previous result has still not been taken.
// Reset (aresetn, synchronous, active low) clears the gains, limits,
// integral and previous error, and empties the output register.
// ----------------------------------------------------------------------------
module line_sensor_pid_controller (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Configuration
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [lspid_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lspid_pkg::CFG_DAT_W-1:0]       cfg_data,
    // Input channel
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [lspid_pkg::SENSOR_W-1:0]        s_sensor_bits,
    input  wire logic [lspid_pkg::TICKS_W-1:0]         s_elapsed_ticks,
    input  wire logic                                  s_clear_integral,
    // Result channel
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [lspid_pkg::LIMIT_W-1:0]       m_correction,
    output logic                                       m_clipped
);
    import lspid_pkg::*;

    logic signed [GAIN_W-1:0]  gain_p_reg;
    logic signed [GAIN_W-1:0]  gain_i_reg;
    logic signed [GAIN_W-1:0]  gain_d_reg;
    logic signed [LIMIT_W-1:0] limit_low_reg;
    logic signed [LIMIT_W-1:0] limit_high_reg;

    logic                      m_valid_reg;
    logic signed [LIMIT_W-1:0] m_correction_reg;
    logic                      m_clipped_reg;

    ctl_t                      ctl;
    logic                      in_ready;
    logic                      out_busy;
    logic signed [LIMIT_W-1:0] result;
    logic                      result_clip;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            limit_low_reg  <= '0;
            limit_high_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_GAIN_P:     gain_p_reg     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:     gain_i_reg     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:     gain_d_reg     <= cfg_data[GAIN_W-1:0];
                REG_LIMIT_LOW:  limit_low_reg  <= cfg_data[LIMIT_W-1:0];
                REG_LIMIT_HIGH: limit_high_reg <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_busy = m_valid_reg && !m_ready;

    lspid_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .out_busy (out_busy),
        .in_ready (in_ready),
        .ctl      (ctl)
    );

    lspid_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (ctl),
        .sensor_bits    (s_sensor_bits),
        .elapsed_ticks  (s_elapsed_ticks),
        .clear_integral (s_clear_integral),
        .gain_p         (gain_p_reg),
        .gain_i         (gain_i_reg),
        .gain_d         (gain_d_reg),
        .limit_low      (limit_low_reg),
        .limit_high     (limit_high_reg),
        .result         (result),
        .result_clip    (result_clip)
    );

    // Ready only in the wait step of the program
    assign s_ready = in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_ld) begin
            m_correction_reg <= result;
            m_clipped_reg    <= result_clip;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_correction = m_correction_reg;
    assign m_clipped    = m_clipped_reg;

    // A result is never loaded over one that has not been transferred
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_ld |-> !(m_valid_reg && !m_ready))
        else $error("result register overwritten");

    // Input and result are never handled in the same step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !ctl.out_ld)
        else $error("input taken during result load");

    // After an input transfer the sequencer is busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second input taken back to back");

endmodule
`default_nettype wire
